/* hdl/sip_pkg.sv */
// shared widths, request/result types and helpers for the segment intersection unit
package sip_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int LO_W    = (CROSS_W + 1) / 2;
    localparam int HI_W    = CROSS_W - LO_W;
    localparam int NUM_W   = CROSS_W + DIFF_W;
    localparam int QUO_W   = COORD_W + 1;
    localparam int SUM_W   = COORD_W + 3;
    localparam int CMAX    = 2 ** (COORD_W - 1) - 1;
    localparam int CMIN    = -(2 ** (COORD_W - 1));

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by_coord;
        coord_t cx;
        coord_t cy;
        coord_t dx;
        coord_t dy;
    } seg_req_t;

    typedef struct packed {
        logic   crosses;
        logic   parallel;
        logic   saturated;
        coord_t point_x;
        coord_t point_y;
    } seg_res_t;

    // values carried alongside the divide
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        logic   crosses;
        logic   parallel;
    } side_t;

    // cross product stage output
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        logic   crosses;
        diff_t  abx;
        diff_t  aby;
        cross_t den;
        cross_t num;
    } crs_t;

    // scaled numerators ready for division
    typedef struct packed {
        logic [NUM_W-1:0]   nx;
        logic [NUM_W-1:0]   ny;
        logic [CROSS_W-1:0] dmag;
        logic               negx;
        logic               negy;
        side_t              side;
    } dvin_t;

    // one divider stage
    typedef struct packed {
        logic [NUM_W-1:0]   remx;
        logic [NUM_W-1:0]   remy;
        logic [CROSS_W-1:0] dmag;
        logic [QUO_W-1:0]   qx;
        logic [QUO_W-1:0]   qy;
        logic               ovfx;
        logic               ovfy;
        logic               negx;
        logic               negy;
        side_t              side;
    } dvst_t;

    function automatic diff_t sdiff(input coord_t a, input coord_t b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic prod_t smul(input diff_t a, input diff_t b);
        return PROD_W'(a) * PROD_W'(b);
    endfunction

    function automatic cross_t csub(input prod_t a, input prod_t b);
        return CROSS_W'(a) - CROSS_W'(b);
    endfunction

    // sign as (positive, negative)
    function automatic logic [1:0] csign(input cross_t v);
        return {(!v[CROSS_W-1]) && (v != '0), v[CROSS_W-1]};
    endfunction

    function automatic logic [CROSS_W-1:0] cmag(input cross_t v);
        return v[CROSS_W-1] ? CROSS_W'(-v) : CROSS_W'(v);
    endfunction

    function automatic logic [DIFF_W-1:0] dmag_of(input diff_t v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

endpackage

/* hdl/sip_cross.sv */
// differences, products and orientation signs, three register stages
module sip_cross
    import sip_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  seg_req_t in_req,
    output logic     out_valid,
    output crs_t     out_data
);

    logic  v1_reg, v2_reg, v3_reg;
    coord_t ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    diff_t adx_reg, ady_reg, bdx_reg, bdy_reg, acx_reg, acy_reg, bcx_reg, bcy_reg;
    diff_t cax_reg, cay_reg, dax_reg, day_reg, cbx_reg, cby_reg, dbx_reg, dby_reg;
    diff_t abx1_reg, aby1_reg, cdx_reg, cdy_reg, abx2_reg, aby2_reg;
    prod_t t1a_reg, t1b_reg, t2a_reg, t2b_reg, t3a_reg, t3b_reg, t4a_reg, t4b_reg;
    prod_t dna_reg, dnb_reg, nma_reg, nmb_reg;
    crs_t  out_reg;
    crs_t  out_next;
    logic [1:0] s1, s2, s3, s4;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage one: coordinate differences
    always_ff @(posedge clk)
    begin
        ax1_reg  <= in_req.ax;
        ay1_reg  <= in_req.ay;
        adx_reg  <= sdiff(in_req.ax, in_req.dx);
        ady_reg  <= sdiff(in_req.ay, in_req.dy);
        bdx_reg  <= sdiff(in_req.bx, in_req.dx);
        bdy_reg  <= sdiff(in_req.by_coord, in_req.dy);
        acx_reg  <= sdiff(in_req.ax, in_req.cx);
        acy_reg  <= sdiff(in_req.ay, in_req.cy);
        bcx_reg  <= sdiff(in_req.bx, in_req.cx);
        bcy_reg  <= sdiff(in_req.by_coord, in_req.cy);
        cax_reg  <= sdiff(in_req.cx, in_req.ax);
        cay_reg  <= sdiff(in_req.cy, in_req.ay);
        dax_reg  <= sdiff(in_req.dx, in_req.ax);
        day_reg  <= sdiff(in_req.dy, in_req.ay);
        cbx_reg  <= sdiff(in_req.cx, in_req.bx);
        cby_reg  <= sdiff(in_req.cy, in_req.by_coord);
        dbx_reg  <= sdiff(in_req.dx, in_req.bx);
        dby_reg  <= sdiff(in_req.dy, in_req.by_coord);
        abx1_reg <= sdiff(in_req.bx, in_req.ax);
        aby1_reg <= sdiff(in_req.by_coord, in_req.ay);
        cdx_reg  <= sdiff(in_req.dx, in_req.cx);
        cdy_reg  <= sdiff(in_req.dy, in_req.cy);
    end

    // stage two: all products
    always_ff @(posedge clk)
    begin
        ax2_reg  <= ax1_reg;
        ay2_reg  <= ay1_reg;
        abx2_reg <= abx1_reg;
        aby2_reg <= aby1_reg;
        t1a_reg  <= smul(adx_reg, bdy_reg);
        t1b_reg  <= smul(ady_reg, bdx_reg);
        t2a_reg  <= smul(acx_reg, bcy_reg);
        t2b_reg  <= smul(acy_reg, bcx_reg);
        t3a_reg  <= smul(cax_reg, day_reg);
        t3b_reg  <= smul(cay_reg, dax_reg);
        t4a_reg  <= smul(cbx_reg, dby_reg);
        t4b_reg  <= smul(cby_reg, dbx_reg);
        dna_reg  <= smul(abx1_reg, cdy_reg);
        dnb_reg  <= smul(aby1_reg, cdx_reg);
        nma_reg  <= smul(cdy_reg, cax_reg);
        nmb_reg  <= smul(cdx_reg, cay_reg);
    end

    // stage three: cross sums, crossing decision
    always_comb
    begin
        s1 = csign(csub(t1a_reg, t1b_reg));
        s2 = csign(csub(t2a_reg, t2b_reg));
        s3 = csign(csub(t3a_reg, t3b_reg));
        s4 = csign(csub(t4a_reg, t4b_reg));
        out_next.ax      = ax2_reg;
        out_next.ay      = ay2_reg;
        out_next.abx     = abx2_reg;
        out_next.aby     = aby2_reg;
        out_next.crosses = ((s1[1] && s2[0]) || (s1[0] && s2[1]))
                        && ((s3[1] && s4[0]) || (s3[0] && s4[1]));
        out_next.den     = csub(dna_reg, dnb_reg);
        out_next.num     = csub(nma_reg, nmb_reg);
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

/* hdl/sip_scale.sv */
// magnitudes and split numerator products, three register stages
module sip_scale
    import sip_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  crs_t  in_data,
    output logic  out_valid,
    output dvin_t out_data
);

    logic v1_reg, v2_reg, v3_reg;
    logic [CROSS_W-1:0] nmag_reg, dmag1_reg, dmag2_reg;
    logic [DIFF_W-1:0]  xm_reg, ym_reg;
    logic negx1_reg, negy1_reg, negx2_reg, negy2_reg;
    side_t side1_reg, side2_reg;
    logic [LO_W+DIFF_W-1:0] pxl_reg, pyl_reg;
    logic [HI_W+DIFF_W-1:0] pxh_reg, pyh_reg;
    dvin_t out_reg;
    logic  nneg, dneg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign nneg = in_data.num[CROSS_W-1];
    assign dneg = in_data.den[CROSS_W-1];

    // stage one: magnitudes and quotient signs
    always_ff @(posedge clk)
    begin
        nmag_reg           <= cmag(in_data.num);
        dmag1_reg          <= cmag(in_data.den);
        xm_reg             <= dmag_of(in_data.abx);
        ym_reg             <= dmag_of(in_data.aby);
        negx1_reg          <= nneg ^ dneg ^ in_data.abx[DIFF_W-1];
        negy1_reg          <= nneg ^ dneg ^ in_data.aby[DIFF_W-1];
        side1_reg.ax       <= in_data.ax;
        side1_reg.ay       <= in_data.ay;
        side1_reg.crosses  <= in_data.crosses;
        side1_reg.parallel <= (in_data.den == '0);
    end

    // stage two: partial products of the numerator
    always_ff @(posedge clk)
    begin
        pxl_reg   <= (LO_W+DIFF_W)'(nmag_reg[LO_W-1:0]) * (LO_W+DIFF_W)'(xm_reg);
        pxh_reg   <= (HI_W+DIFF_W)'(nmag_reg[CROSS_W-1:LO_W]) * (HI_W+DIFF_W)'(xm_reg);
        pyl_reg   <= (LO_W+DIFF_W)'(nmag_reg[LO_W-1:0]) * (LO_W+DIFF_W)'(ym_reg);
        pyh_reg   <= (HI_W+DIFF_W)'(nmag_reg[CROSS_W-1:LO_W]) * (HI_W+DIFF_W)'(ym_reg);
        dmag2_reg <= dmag1_reg;
        negx2_reg <= negx1_reg;
        negy2_reg <= negy1_reg;
        side2_reg <= side1_reg;
    end

    // stage three: combine partial products
    always_ff @(posedge clk)
    begin
        out_reg.nx   <= NUM_W'(pxl_reg) + (NUM_W'(pxh_reg) << LO_W);
        out_reg.ny   <= NUM_W'(pyl_reg) + (NUM_W'(pyh_reg) << LO_W);
        out_reg.dmag <= dmag2_reg;
        out_reg.negx <= negx2_reg;
        out_reg.negy <= negy2_reg;
        out_reg.side <= side2_reg;
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

/* hdl/sip_div.sv */
// pipelined restoring divider for both coordinates, one quotient bit per stage
module sip_div
    import sip_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  dvin_t in_data,
    output logic  out_valid,
    output dvst_t out_data
);

    dvst_t st_reg [0:QUO_W];
    logic  v_reg  [0:QUO_W];
    dvst_t first_next;
    logic [NUM_W-1:0] dtop;

    // range check: a quotient of more than QUO_W bits saturates unless the lines are parallel
    always_comb
    begin
        dtop            = NUM_W'(in_data.dmag) << QUO_W;
        first_next.remx = in_data.nx;
        first_next.remy = in_data.ny;
        first_next.dmag = in_data.dmag;
        first_next.qx   = '0;
        first_next.qy   = '0;
        first_next.ovfx = (in_data.nx >= dtop);
        first_next.ovfy = (in_data.ny >= dtop);
        first_next.negx = in_data.negx;
        first_next.negy = in_data.negy;
        first_next.side = in_data.side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= first_next;
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        dvst_t st_next;
        logic [NUM_W-1:0] trial;
        logic ge_x, ge_y;

        always_comb
        begin
            trial   = NUM_W'(st_reg[k].dmag) << (QUO_W - 1 - k);
            ge_x    = (st_reg[k].remx >= trial);
            ge_y    = (st_reg[k].remy >= trial);
            st_next = st_reg[k];
            if (ge_x)
            begin
                st_next.remx = st_reg[k].remx - trial;
            end
            if (ge_y)
            begin
                st_next.remy = st_reg[k].remy - trial;
            end
            st_next.qx[QUO_W-1-k] = ge_x;
            st_next.qy[QUO_W-1-k] = ge_y;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            st_reg[k+1] <= st_next;
        end
    end

    assign out_valid = v_reg[QUO_W];
    assign out_data  = st_reg[QUO_W];

endmodule

/* hdl/segment_intersection_point_unit.sv */
// segment intersection unit: orientation test and intersection point, fully pipelined
// throughput: one request per cycle; busy is always low, the pipeline never stalls
// depth set by the 26-stage divider (range check plus 25 quotient bits) and 7 other stages
// reset clears only the valid bits; results leave on done for exactly one cycle
module segment_intersection_point_unit
    import sip_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  seg_req_t req,
    output logic     done,
    output seg_res_t result
);

    logic  crs_valid, dv_valid, q_valid;
    crs_t  crs_data;
    dvin_t dv_data;
    dvst_t q_data;
    logic  done_reg;
    seg_res_t res_reg, res_next;
    logic signed [SUM_W-1:0] qxs, qys, sx, sy;
    logic sat_x, sat_y;

    sip_cross u_cross
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_req    (req),
        .out_valid (crs_valid),
        .out_data  (crs_data)
    );

    sip_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (crs_valid),
        .in_data   (crs_data),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    sip_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_data   (dv_data),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    // add offset to the start point and clamp each coordinate
    always_comb
    begin
        qxs = $signed(SUM_W'(q_data.qx));
        qys = $signed(SUM_W'(q_data.qy));
        if (q_data.negx)
        begin
            qxs = -qxs;
        end
        if (q_data.negy)
        begin
            qys = -qys;
        end
        sx = SUM_W'(q_data.side.ax) + qxs;
        sy = SUM_W'(q_data.side.ay) + qys;

        res_next.crosses  = q_data.side.crosses;
        res_next.parallel = q_data.side.parallel;
        sat_x = 1'b0;
        sat_y = 1'b0;
        res_next.point_x = COORD_W'(sx);
        res_next.point_y = COORD_W'(sy);

        if (q_data.ovfx || sx > SUM_W'(CMAX) || sx < SUM_W'(CMIN))
        begin
            sat_x = 1'b1;
            res_next.point_x = q_data.negx ? COORD_W'(CMIN) : COORD_W'(CMAX);
            if (!q_data.ovfx)
            begin
                res_next.point_x = sx[SUM_W-1] ? COORD_W'(CMIN) : COORD_W'(CMAX);
            end
        end
        if (q_data.ovfy || sy > SUM_W'(CMAX) || sy < SUM_W'(CMIN))
        begin
            sat_y = 1'b1;
            res_next.point_y = q_data.negy ? COORD_W'(CMIN) : COORD_W'(CMAX);
            if (!q_data.ovfy)
            begin
                res_next.point_y = sy[SUM_W-1] ? COORD_W'(CMIN) : COORD_W'(CMAX);
            end
        end
        res_next.saturated = sat_x || sat_y;

        // parallel lines give the origin
        if (q_data.side.parallel)
        begin
            res_next.saturated = 1'b0;
            res_next.point_x   = '0;
            res_next.point_y   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* bench/tb_segment_intersection_point_unit.sv */
// self-checking bench for the segment intersection unit
module tb_segment_intersection_point_unit;
    import sip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    seg_req_t req;
    logic     done;
    seg_res_t result;

    seg_req_t pending_q[$];
    seg_res_t expected_q[$];
    int       err_count;
    int       send_idle_pct;

    segment_intersection_point_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // clamp a wide signed value to the coordinate range
    function automatic coord_t clamp_coord(input logic signed [127:0] v, inout bit sat);
        if (v > 128'sd8388607)
        begin
            sat = 1'b1;
            return coord_t'(24'h7fffff);
        end
        if (v < -128'sd8388608)
        begin
            sat = 1'b1;
            return coord_t'(24'h800000);
        end
        return coord_t'(v[23:0]);
    endfunction

    // orientation sign of r relative to line pq
    function automatic int orient(input logic signed [127:0] px, py, qx, qy, rx, ry);
        logic signed [127:0] t;
        t = (px - rx) * (qy - ry) - (py - ry) * (qx - rx);
        return (t > 0) ? 1 : ((t < 0) ? -1 : 0);
    endfunction

    // predict the intersection result for one request
    function automatic seg_res_t predict_intersection(input seg_req_t r);
        logic signed [127:0] ax, ay, bx, by, cx, cy, dx, dy;
        logic signed [127:0] den, num, ox, oy;
        seg_res_t o;
        bit sat;
        int s1, s2, s3, s4;
        ax = r.ax; ay = r.ay; bx = r.bx; by = r.by_coord;
        cx = r.cx; cy = r.cy; dx = r.dx; dy = r.dy;
        s1 = orient(ax, ay, bx, by, dx, dy);
        s2 = orient(ax, ay, bx, by, cx, cy);
        s3 = orient(cx, cy, dx, dy, ax, ay);
        s4 = orient(cx, cy, dx, dy, bx, by);
        o = '0;
        sat = 1'b0;
        o.crosses = (s1 * s2 < 0) && (s3 * s4 < 0);
        den = (bx - ax) * (dy - cy) - (by - ay) * (dx - cx);
        o.parallel = (den == 0);
        if (!o.parallel)
        begin
            num = (dy - cy) * (cx - ax) - (dx - cx) * (cy - ay);
            // signed division in sv truncates toward zero
            ox = (num * (bx - ax)) / den;
            oy = (num * (by - ay)) / den;
            o.point_x = clamp_coord(ax + ox, sat);
            o.point_y = clamp_coord(ay + oy, sat);
        end
        o.saturated = sat;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got, exp_v);
        err_count++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_v, $realtime);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'(24'h7fffff - $urandom_range(0, 3));
            1: return coord_t'(24'h800000 + $urandom_range(0, 3));
            2: return coord_t'($urandom_range(0, 64) - 32);
            3: return coord_t'($urandom_range(0, 8191) - 4096);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // driver: request on start, busy respected
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            if (!(start && busy))
            begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    start <= 1'b1;
                    req   <= pending_q[0];
                    expected_q.push_back(predict_intersection(pending_q[0]));
                    void'(pending_q.pop_front());
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", result, 0);
            end
            else
            begin
                if (result.crosses !== expected_q[0].crosses)
                    report_mismatch("crosses", result.crosses, expected_q[0].crosses);
                if (result.parallel !== expected_q[0].parallel)
                    report_mismatch("parallel", result.parallel, expected_q[0].parallel);
                if (result.saturated !== expected_q[0].saturated)
                    report_mismatch("saturated", result.saturated, expected_q[0].saturated);
                if (result.point_x !== expected_q[0].point_x)
                    report_mismatch("point_x", result.point_x, expected_q[0].point_x);
                if (result.point_y !== expected_q[0].point_y)
                    report_mismatch("point_y", result.point_y, expected_q[0].point_y);
                void'(expected_q.pop_front());
            end
        end
    end

    // stimulus
    initial
    begin
        seg_req_t r;
        err_count     = 0;
        send_idle_pct = 18;
        rst_n         = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: crossing, touching, collinear, parallel, degenerate, extremes
        r = '{24'sd0, 24'sd0, 24'sd2560, 24'sd2560, 24'sd0, 24'sd2560, 24'sd2560, 24'sd0};
        pending_q.push_back(r);
        r = '{24'sd0, 24'sd0, 24'sd2560, 24'sd0, 24'sd1280, 24'sd0, 24'sd1280, 24'sd2560};
        pending_q.push_back(r);
        r = '{24'sd0, 24'sd0, 24'sd256, 24'sd256, 24'sd512, 24'sd512, 24'sd768, 24'sd768};
        pending_q.push_back(r);
        r = '{24'sd0, 24'sd0, 24'sd256, 24'sd0, 24'sd0, 24'sd256, 24'sd256, 24'sd256};
        pending_q.push_back(r);
        r = '{24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd0, 24'sd9, 24'sd9, 24'sd0};
        pending_q.push_back(r);
        r = '{24'sd0, 24'sd0, 24'sd1, 24'sd1, 24'sd0, 24'sd1, 24'sd3, 24'sd0};
        pending_q.push_back(r);
        // nearly parallel lines with a far-away point
        r = '{-24'sd8388608, 24'sd0, 24'sd8388607, 24'sd1,
              -24'sd8388608, 24'sd1, 24'sd8388607, 24'sd3};
        pending_q.push_back(r);
        r = '{24'sd8388607, -24'sd8388608, -24'sd8388608, 24'sd8388607,
              -24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607};
        pending_q.push_back(r);
        r = '{24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd8388607, 24'sd0, 24'sd8388607, 24'sd1};
        pending_q.push_back(r);
        r = '{24'sd0, 24'sd0, -24'sd1, 24'sd0, -24'sd8388608, -24'sd8388608,
              -24'sd8388608, 24'sd8388607};
        pending_q.push_back(r);
        pending_q.push_back('1);
        pending_q.push_back('0);
        pending_q.push_back({8{24'h800000}});
        pending_q.push_back({8{24'h7fffff}});

        // random phases with different sender idling
        for (int ph = 0; ph < 3; ph++)
        begin
            for (int i = 0; i < 600; i++)
            begin
                for (int k = 0; k < 8; k++)
                    r[k*24 +: 24] = rand_coord();
                // degenerate or parallel now and then
                if ($urandom_range(0, 15) == 0)
                begin
                    r.bx = r.ax;
                    r.by_coord = r.ay;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    r.dx = r.cx + (r.bx - r.ax);
                    r.dy = r.cy + (r.by_coord - r.ay);
                end
                pending_q.push_back(r);
            end
            wait (pending_q.size() == 0);
            send_idle_pct = (ph == 0) ? 77 : 0;
        end
        wait (pending_q.size() == 0);
        @(posedge clk);
        wait (expected_q.size() == 0);
        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
hdl/sip_pkg.sv
hdl/sip_cross.sv
hdl/sip_scale.sv
hdl/sip_div.sv
hdl/segment_intersection_point_unit.sv
bench/tb_segment_intersection_point_unit.sv
